### rtl/bba_pkg.sv
// Package for the block bitmap allocator.
// Holds shared constants, the command and state encodings, and the
// controller-to-datapath command struct and the status struct back. No dependencies.
package bba_pkg;

    localparam int WORD_W = 32;
    localparam int BIT_W = 5;
    localparam int ADDR_W = 32;
    localparam int BNUM_W = 15;
    localparam int CMD_W = 2;
    localparam int DEF_BLOCK_SHIFT = 12;
    localparam int DEF_NUM_BLOCKS = 32768;

    typedef enum logic [CMD_W-1:0] {
        CMD_MARK  = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_RANGE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_READ,
        ST_MODIFY,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic setup;
        logic rd;
        logic wr;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic clr_done;
        logic skip;
        logic at_last;
        logic out_free;
    } stat_t;

endpackage

### rtl/bba_ctrl.sv
// Controller state machine of the block bitmap allocator.
// Sequences clearing, setup and word read-modify-write passes.
// Depends on bba_pkg.
module bba_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bba_pkg::stat_t stat,
    output bba_pkg::ctrl_t ctrl
);

    bba_pkg::state_t state_reg;
    bba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        in_stall = 1'b1;
        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                ctrl.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    state_next = bba_pkg::ST_SETUP;
                end
            end
            bba_pkg::ST_SETUP:
            begin
                ctrl.setup = 1'b1;
                state_next = stat.skip ? bba_pkg::ST_FINISH : bba_pkg::ST_READ;
            end
            bba_pkg::ST_READ:
            begin
                ctrl.rd = 1'b1;
                state_next = bba_pkg::ST_MODIFY;
            end
            bba_pkg::ST_MODIFY:
            begin
                ctrl.wr = 1'b1;
                state_next = stat.at_last ? bba_pkg::ST_FINISH : bba_pkg::ST_READ;
            end
            bba_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    ctrl.finish = 1'b1;
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/bba_datapath.sv
// Datapath of the block bitmap allocator: bitmap word memory, range and
// word-mask computation, and the result register. Depends on bba_pkg.
module bba_datapath
#(
    parameter int BLOCK_SHIFT = bba_pkg::DEF_BLOCK_SHIFT,
    parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  bba_pkg::ctrl_t             ctrl,
    output bba_pkg::stat_t             stat,
    input  logic [bba_pkg::CMD_W-1:0]  command,
    input  logic [bba_pkg::BNUM_W-1:0] block_number,
    input  logic [bba_pkg::ADDR_W-1:0] start_address,
    input  logic [bba_pkg::ADDR_W-1:0] byte_length,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       is_allocated,
    output logic                       out_of_range
);

    localparam int BLK_W = $clog2(NUM_BLOCKS);
    localparam int WADDR_W = BLK_W - bba_pkg::BIT_W;
    localparam int NUM_WORDS = NUM_BLOCKS / bba_pkg::WORD_W;
    localparam int EXT_W = bba_pkg::ADDR_W - BLOCK_SHIFT + 1;
    localparam int MAX_A = (EXT_W > BLK_W + 1) ? EXT_W : BLK_W + 1;
    localparam int CMP_W = (MAX_A > bba_pkg::BNUM_W + 1) ? MAX_A : bba_pkg::BNUM_W + 1;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(NUM_BLOCKS);
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

    logic [bba_pkg::WORD_W-1:0] mem [NUM_WORDS];

    bba_pkg::cmd_t              cmd_reg;
    logic [CMP_W-1:0]           blk_reg;
    logic [CMP_W-1:0]           first_reg;
    logic [CMP_W-1:0]           end_reg;
    logic [WADDR_W-1:0]         cur_reg;
    logic [WADDR_W-1:0]         last_reg;
    logic [bba_pkg::BIT_W-1:0]  lo_reg;
    logic [bba_pkg::BIT_W-1:0]  hi_reg;
    logic                       oor_reg;
    logic                       alloc_reg;
    logic [WADDR_W-1:0]         clr_reg;
    logic [bba_pkg::WORD_W-1:0] rdata_reg;
    logic                       out_valid_reg;
    logic                       is_allocated_reg;
    logic                       out_of_range_reg;

    logic                       is_range;
    logic                       range_oor;
    logic                       blk_out;
    logic [CMP_W-1:0]           stop;
    logic [CMP_W-1:0]           stop_m1;
    logic [CMP_W-1:0]           setup_first;
    logic [CMP_W-1:0]           setup_last;
    logic [CMP_W-1:0]           first_calc;
    logic                       at_last;
    logic [bba_pkg::WORD_W-1:0] mask;
    logic [bba_pkg::WORD_W-1:0] new_word;
    logic                       mem_we;

    assign is_range = (cmd_reg == bba_pkg::CMD_RANGE);
    assign range_oor = (end_reg > LIMIT);
    assign blk_out = (blk_reg >= LIMIT);
    assign stop = range_oor ? LIMIT : end_reg;
    assign stop_m1 = stop - CMP_W'(1);
    assign setup_first = is_range ? first_reg : blk_reg;
    assign setup_last = is_range ? stop_m1 : blk_reg;
    assign first_calc = CMP_W'(start_address >> BLOCK_SHIFT);
    assign at_last = (cur_reg == last_reg);

    always_comb
    begin
        for (int i = 0; i < bba_pkg::WORD_W; i++)
        begin
            mask[i] = (bba_pkg::BIT_W'(i) >= lo_reg)
                      && (!at_last || (bba_pkg::BIT_W'(i) <= hi_reg));
        end
    end

    assign new_word = (cmd_reg == bba_pkg::CMD_FREE) ? (rdata_reg & ~mask)
                                                     : (rdata_reg | mask);
    assign mem_we = ctrl.wr && (cmd_reg != bba_pkg::CMD_TEST);

    assign stat.clr_done = (clr_reg == LAST_WORD);
    assign stat.skip = is_range ? (first_reg >= LIMIT) : blk_out;
    assign stat.at_last = at_last;
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (ctrl.clr_step)
        begin
            mem[clr_reg] <= '0;
        end
        else if (mem_we)
        begin
            mem[cur_reg] <= new_word;
        end
        if (ctrl.rd)
        begin
            rdata_reg <= mem[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctrl.clr_step)
        begin
            clr_reg <= clr_reg + WADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= bba_pkg::cmd_t'(command);
            blk_reg <= CMP_W'(block_number);
            first_reg <= first_calc;
            end_reg <= first_calc + CMP_W'(byte_length >> BLOCK_SHIFT) + CMP_W'(1);
            alloc_reg <= 1'b0;
        end
        if (ctrl.setup)
        begin
            cur_reg <= setup_first[BLK_W-1:bba_pkg::BIT_W];
            lo_reg <= setup_first[bba_pkg::BIT_W-1:0];
            last_reg <= setup_last[BLK_W-1:bba_pkg::BIT_W];
            hi_reg <= setup_last[bba_pkg::BIT_W-1:0];
            oor_reg <= is_range ? range_oor : blk_out;
        end
        if (ctrl.wr)
        begin
            cur_reg <= cur_reg + WADDR_W'(1);
            lo_reg <= '0;
            if (cmd_reg == bba_pkg::CMD_TEST)
            begin
                alloc_reg <= rdata_reg[hi_reg];
            end
        end
        if (ctrl.finish)
        begin
            is_allocated_reg <= alloc_reg;
            out_of_range_reg <= oor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_allocated = is_allocated_reg;
    assign out_of_range = out_of_range_reg;

endmodule

### rtl/block_bitmap_allocator.sv
// Top level of the block bitmap allocator: one allocated bit per memory block.
// Instantiates bba_ctrl and bba_datapath; depends on bba_pkg.
//
// After reset the bitmap is cleared one 32-bit word per cycle; no command is
// taken until the clear is done. Mark, free and test of a single block go
// through setup, one read and one write of the bitmap word memory (test does
// not write), then the result is loaded into the output register. A block
// beyond the bitmap skips the read and write. Range marking does a
// read-modify-write of every bitmap word the range touches, word by word,
// through the single port of the word memory. A new command is accepted
// while a result still waits in the output register.
module block_bitmap_allocator
#(
    parameter int BLOCK_SHIFT = bba_pkg::DEF_BLOCK_SHIFT,
    parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [bba_pkg::CMD_W-1:0]  command,
    input  logic [bba_pkg::BNUM_W-1:0] block_number,
    input  logic [bba_pkg::ADDR_W-1:0] start_address,
    input  logic [bba_pkg::ADDR_W-1:0] byte_length,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       is_allocated,
    output logic                       out_of_range
);

    bba_pkg::ctrl_t ctrl;
    bba_pkg::stat_t stat;

    bba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bba_datapath
    #(
        .BLOCK_SHIFT (BLOCK_SHIFT),
        .NUM_BLOCKS  (NUM_BLOCKS)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (command),
        .block_number  (block_number),
        .start_address (start_address),
        .byte_length   (byte_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_allocated  (is_allocated),
        .out_of_range  (out_of_range)
    );

endmodule
